### design/rbfs_pkg.sv
package rbfs_pkg;

    // storage geometry
    localparam int RING_DEPTH = 32;
    localparam int MAX_TAPS   = 32;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int COEF_AW    = $clog2(MAX_TAPS);
    localparam int TAP_LIMIT  = (MAX_TAPS < RING_DEPTH) ? MAX_TAPS : RING_DEPTH;

    // field widths
    localparam int TAP_W  = 6;
    localparam int SAMP_W = 16;
    localparam int IDX_W  = 5;
    localparam int COEF_W = 18;
    localparam int PROD_W = SAMP_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int FRAC_W = 16;
    localparam int Q_W    = ACC_W - FRAC_W;

    // configuration register
    localparam int              CFG_AW        = 3;
    localparam int              CFG_DW        = 32;
    localparam logic            REG_TAP_COUNT = 1'b0;
    localparam logic [TAP_W-1:0] TAP_RESET    = TAP_W'(21);

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // one classified command between front and back
    typedef struct packed {
        logic                     is_load;
        logic signed [SAMP_W-1:0] sample;
        logic [IDX_W-1:0]         index;
        logic signed [COEF_W-1:0] value;
    } cmd_t;

endpackage

### design/rbfs_front.sv
module rbfs_front
    import rbfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [SAMP_W-1:0] sample,
    input  logic [IDX_W-1:0]         coeff_index,
    input  logic signed [COEF_W-1:0] coeff_value,
    output logic                     cmd_valid,
    output cmd_t                     cmd,
    input  logic                     cmd_pop
);

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       entry_reg [2];
    cmd_t       cmd_in;
    logic       push;
    logic       pop;

    // classify the incoming beat
    always_comb
    begin
        cmd_in.is_load = (operation == OP_LOAD);
        cmd_in.sample  = sample;
        cmd_in.index   = coeff_index;
        cmd_in.value   = coeff_value;
    end

    // two-entry queue towards the back end
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### design/rbfs_back.sv
module rbfs_back
    import rbfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [TAP_W-1:0]         tap_count,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output logic                     cmd_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SAMP_W-1:0] smoothed,
    output logic                     saturated,
    output logic                     fin
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [RING_AW-1:0]       wp_reg, wp_next;
    logic [RING_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [TAP_W-1:0]         cnt_reg, cnt_next;
    logic [TAP_W-1:0]         taps_reg, taps_next;
    logic [TAP_W-1:0]         taps_use;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     s1_reg, s2_reg;
    logic                     issue;
    logic                     ring_we, coef_we;
    logic                     out_load;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SAMP_W-1:0] smoothed_reg;
    logic                     saturated_reg;

    logic signed [SAMP_W-1:0] ring_mem [RING_DEPTH];
    logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];
    logic [RING_DEPTH-1:0]    ring_vld_reg;
    logic [MAX_TAPS-1:0]      coef_vld_reg;

    logic signed [SAMP_W-1:0] samp_rd_reg;
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic                     samp_ok_reg, coef_ok_reg;
    logic signed [SAMP_W-1:0] samp_m;
    logic signed [COEF_W-1:0] coef_m;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [Q_W-1:0]    q_floor, q_trunc;
    logic                     q_hi, q_lo;
    logic signed [SAMP_W-1:0] q_sat;

    // taps in use, clamped to one .. limit
    always_comb
    begin
        if (tap_count == '0)
        begin
            taps_use = TAP_W'(1);
        end
        else if (tap_count > TAP_W'(TAP_LIMIT))
        begin
            taps_use = TAP_W'(TAP_LIMIT);
        end
        else
        begin
            taps_use = tap_count;
        end
    end

    // truncate toward zero, then saturate
    always_comb
    begin
        q_floor = acc_reg[ACC_W-1:FRAC_W];
        if (acc_reg[ACC_W-1] && (acc_reg[FRAC_W-1:0] != '0))
        begin
            q_trunc = q_floor + Q_W'(1);
        end
        else
        begin
            q_trunc = q_floor;
        end
        q_hi = (q_trunc > Q_W'(32767));
        q_lo = (q_trunc < -Q_W'(32768));
        if (q_hi)
        begin
            q_sat = 16'sh7fff;
        end
        else if (q_lo)
        begin
            q_sat = 16'sh8000;
        end
        else
        begin
            q_sat = q_trunc[SAMP_W-1:0];
        end
    end

    // sequencer: one multiply-accumulate issue per tap
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rd_ptr_next    = rd_ptr_reg;
        cnt_next       = cnt_reg;
        taps_next      = taps_reg;
        acc_next       = acc_reg;
        cmd_pop        = 1'b0;
        ring_we        = 1'b0;
        coef_we        = 1'b0;
        issue          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s2_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_load)
                    begin
                        coef_we = (32'(cmd.index) < MAX_TAPS);
                    end
                    else
                    begin
                        ring_we     = 1'b1;
                        wp_next     = wp_reg + RING_AW'(1);
                        rd_ptr_next = wp_reg + RING_AW'(1) - taps_use[RING_AW-1:0];
                        taps_next   = taps_use;
                        cnt_next    = '0;
                        acc_next    = '0;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                issue       = 1'b1;
                rd_ptr_next = rd_ptr_reg + RING_AW'(1);
                cnt_next    = cnt_reg + TAP_W'(1);
                if (cnt_reg == taps_reg - TAP_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg && !s2_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            ring_vld_reg  <= '0;
            coef_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            s1_reg        <= issue;
            s2_reg        <= s1_reg;
            out_valid_reg <= out_valid_next;
            if (ring_we)
            begin
                ring_vld_reg[wp_reg] <= 1'b1;
            end
            if (coef_we)
            begin
                coef_vld_reg[cmd.index[COEF_AW-1:0]] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        cnt_reg    <= cnt_next;
        taps_reg   <= taps_next;
        acc_reg    <= acc_next;
        prod_reg   <= coef_m * samp_m;
        if (out_load)
        begin
            smoothed_reg  <= q_sat;
            saturated_reg <= q_hi || q_lo;
        end
    end

    // sample ring and coefficient table, registered reads
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= cmd.sample;
        end
        if (coef_we)
        begin
            coef_mem[cmd.index[COEF_AW-1:0]] <= cmd.value;
        end
        if (issue)
        begin
            samp_rd_reg <= ring_mem[rd_ptr_reg];
            samp_ok_reg <= ring_vld_reg[rd_ptr_reg];
            coef_rd_reg <= coef_mem[cnt_reg[COEF_AW-1:0]];
            coef_ok_reg <= coef_vld_reg[cnt_reg[COEF_AW-1:0]];
        end
    end

    // unwritten entries read as zero
    assign samp_m = samp_ok_reg ? samp_rd_reg : '0;
    assign coef_m = coef_ok_reg ? coef_rd_reg : '0;

    assign out_valid = out_valid_reg;
    assign smoothed  = smoothed_reg;
    assign saturated = saturated_reg;
    assign fin       = (state_reg == ST_FIN);

endmodule

### design/ring_buffer_fir_smoother.sv
// A push beat's sum is built over the t taps in use (1 .. 32) in the run, drain and finish
// states, then loaded into the output register; a load beat only writes the coefficient table.
// The single multiply-accumulate unit steps one tap per cycle, and the back end takes no new
// push until the last sum has been handed to the output register.
// Reset (rst_n low, asynchronous): queue and pipeline empty, tap_count 21, write pointer
// zero, valid bits cleared so sample ring and coefficient table read as zero.
module ring_buffer_fir_smoother
    import rbfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [CFG_DW-1:0]        pwdata,
    output logic [CFG_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [SAMP_W-1:0] sample,
    input  logic [IDX_W-1:0]         coeff_index,
    input  logic signed [COEF_W-1:0] coeff_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SAMP_W-1:0] smoothed,
    output logic                     saturated
);

    logic [TAP_W-1:0] tap_count_reg;
    logic             cfg_wr;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;
    logic             bk_fin;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TAP_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_RESET;
        end
        else if (cfg_wr)
        begin
            tap_count_reg <= pwdata[TAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TAP_COUNT)
        begin
            prdata = CFG_DW'(tap_count_reg);
        end
    end

    // front end: accept and classify beats
    rbfs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .sample      (sample),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // back end: storage, multiply-accumulate and result register
    rbfs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_count (tap_count_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .smoothed  (smoothed),
        .saturated (saturated),
        .fin       (bk_fin)
    );

    // a flagged result sits at one of the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (smoothed == 16'sh7fff || smoothed == 16'sh8000))
        else $error("saturated result not at a range limit");

    // a new result only appears out of the finishing step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(bk_fin))
        else $error("result appeared without a finished sum");

    // a finished sum with a free output slot is delivered next cycle
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_fin && !out_valid) |=> out_valid)
        else $error("finished sum not moved to the output");

endmodule
